// ===== rtl/core/mlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants of the three-level feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

	localparam int TimeW  = 24;
	localparam int BurstW = 16;
	localparam int IdW    = 4;
	localparam int LevelW = 2;
	localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

	localparam logic [1:0] RegQuantum0 = 2'd0;
	localparam logic [1:0] RegQuantum1 = 2'd1;
	localparam logic [1:0] RegSwitch   = 2'd2;

	localparam logic CmdArrive = 1'b0;
	localparam logic CmdTick   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic read;
		logic exec;
		logic load_out;
	} ctrl_t;

	typedef struct packed {
		logic is_tick;
	} status_t;

endpackage

// ===== rtl/core/mlfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Sequencer: accept a request, read the task tables, execute, present a tick result.
// ----------------------------------------------------------------------------
module mlfq_ctrl import mlfq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output ctrl_t   ctrl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_READ;
			ST_READ: state_d = ST_EXEC;
			ST_EXEC: state_d = status.is_tick ? ST_OUT : ST_IDLE;
			ST_OUT:  if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		out_valid     = (state_q == ST_OUT);
		ctrl.capture  = (state_q == ST_IDLE) && in_valid;
		ctrl.read     = (state_q == ST_READ);
		ctrl.exec     = (state_q == ST_EXEC);
		ctrl.load_out = (state_q == ST_EXEC) && status.is_tick;
	end

	a_out_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_EXEC))
		else $error("result shown without execute step");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("ready while result pending");
	a_read_follows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.capture |=> ctrl.read)
		else $error("capture not followed by read");

endmodule

// ===== rtl/core/mlfq_dp.sv =====
// ----------------------------------------------------------------------------
// mlfq_dp
// Task tables, level queues, run state, time counter and result registers.
// ----------------------------------------------------------------------------
module mlfq_dp import mlfq_pkg::*; #(
	parameter int MaxTasks = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_t             ctrl,
	output status_t           status,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [7:0]        cfg_data,
	input  logic              command,
	input  logic [IdW-1:0]    task_id,
	input  logic [BurstW-1:0] burst_length,
	output logic              running_valid,
	output logic [IdW-1:0]    running_task,
	output logic [LevelW-1:0] running_level,
	output logic              done_valid,
	output logic [IdW-1:0]    done_task,
	output logic [TimeW-1:0]  finish_time,
	output logic [TimeW-1:0]  turnaround_time,
	output logic [TimeW-1:0]  waiting_time,
	output logic [TimeW-1:0]  response_time
);

	localparam int TW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
	localparam int CW = $clog2(MaxTasks + 1);
	localparam logic [CW-1:0] Full = CW'(MaxTasks);
	localparam logic [CW:0] Depth = (CW+1)'(MaxTasks);
	localparam logic [TW-1:0] LastSlot = TW'(MaxTasks - 1);

	logic [7:0] q0_q, q1_q;
	logic [3:0] sw_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q0_q <= 8'd8;
			q1_q <= 8'd16;
			sw_q <= 4'd0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				RegQuantum0: q0_q <= cfg_data;
				RegQuantum1: q1_q <= cfg_data;
				RegSwitch:   sw_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	logic              cmd_q;
	logic [IdW-1:0]    id_q;
	logic [BurstW-1:0] burst_q;
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q   <= command;
			id_q    <= task_id;
			burst_q <= burst_length;
		end
	end
	assign status.is_tick = (cmd_q == CmdTick);

	logic [TimeW-1:0]  arr_m [MaxTasks];
	logic [TimeW-1:0]  start_m [MaxTasks];
	logic [BurstW-1:0] burst_m [MaxTasks];
	logic [BurstW-1:0] rem_m [MaxTasks];
	logic [IdW-1:0]    fifo_m [3][MaxTasks];
	logic [MaxTasks-1:0] active_q, started_q;
	logic [TW-1:0] head_q [3];
	logic [CW-1:0] cnt_q [3];
	logic              run_v_q;
	logic [TW-1:0]     run_t_q;
	logic [LevelW-1:0] run_l_q;
	logic [7:0]        slice_q;
	logic [3:0]        swl_q;
	logic [TimeW-1:0]  time_q;

	// Read stage: running task's record and the three queue heads.
	logic [TimeW-1:0]  r_arr_s1, r_start_s1;
	logic [BurstW-1:0] r_burst_s1, r_rem_s1;
	logic [IdW-1:0]    r_head_s1 [3];
	always_ff @(posedge clk) begin
		if (ctrl.read) begin
			r_arr_s1   <= arr_m[run_t_q];
			r_start_s1 <= start_m[run_t_q];
			r_burst_s1 <= burst_m[run_t_q];
			r_rem_s1   <= rem_m[run_t_q];
			for (int l = 0; l < 3; l++) r_head_s1[l] <= fifo_m[l][head_q[l]];
		end
	end

	logic id_ok;
	assign id_ok = ({{(32-IdW){1'b0}}, id_q} < MaxTasks);
	logic [TW-1:0] aid;
	assign aid = TW'(id_q);
	logic arrive_ok;
	assign arrive_ok = ctrl.exec && !status.is_tick && id_ok && !active_q[aid]
		&& (burst_q != '0);

	// Tick decisions.
	logic complete, demote, any_wait, sw_busy, pick;
	logic [1:0] plvl;
	logic [TimeW-1:0] turn, resp;
	logic [TW-1:0] ptask;
	logic [TW-1:0] push_pos0, push_pos_d;
	logic [CW:0] sum0, sumd;
	logic push_d_ok;
	always_comb begin
		any_wait = (cnt_q[0] != '0) || (cnt_q[1] != '0) || (cnt_q[2] != '0);
		complete = run_v_q && (r_rem_s1 == '0);
		demote = run_v_q && !complete &&
			((run_l_q == 2'd0 && slice_q >= q0_q) || (run_l_q == 2'd1 && slice_q >= q1_q));
		sw_busy = complete ? (any_wait && sw_q != '0) :
			demote ? (sw_q != '0) : (swl_q != '0);
		plvl = (cnt_q[0] != '0) ? 2'd0 : (cnt_q[1] != '0) ? 2'd1 : 2'd2;
		pick = !sw_busy && (!run_v_q || complete || demote) &&
			(any_wait || demote);
		turn = time_q - r_arr_s1;
		resp = r_start_s1 - r_arr_s1;
		sum0 = (CW+1)'(head_q[0]) + (CW+1)'(cnt_q[0]);
		sumd = (CW+1)'(head_q[run_l_q + 2'd1]) + (CW+1)'(cnt_q[run_l_q + 2'd1]);
		push_pos0 = TW'((sum0 >= Depth) ? sum0 - Depth : sum0);
		push_pos_d = TW'((sumd >= Depth) ? sumd - Depth : sumd);
		push_d_ok = cnt_q[run_l_q + 2'd1] < Full;
		ptask = TW'(r_head_s1[plvl]);
	end

	// Pick level with a demotion into an empty lower queue: the demoted task
	// itself lands there, so the heads captured in the read stage still hold
	// for non-empty levels; handle the demoted-alone case explicitly.
	logic [1:0] plvl2;
	logic [TW-1:0] ptask2;
	always_comb begin
		plvl2 = plvl;
		ptask2 = ptask;
		if (demote && !any_wait) begin
			plvl2 = run_l_q + 2'd1;
			ptask2 = run_t_q;
		end else if (demote && plvl == 2'd2 && cnt_q[2] == '0) begin
			plvl2 = run_l_q + 2'd1;
			ptask2 = run_t_q;
		end else if (demote && plvl == 2'd2 && run_l_q == 2'd0 && cnt_q[1] == '0) begin
			plvl2 = 2'd1;
			ptask2 = run_t_q;
		end
	end

	logic run_now;
	logic [TW-1:0] rt;
	logic [LevelW-1:0] rl;
	assign run_now = !sw_busy && ((run_v_q && !complete && !demote) || pick);
	assign rt = (run_v_q && !complete && !demote) ? run_t_q : ptask2;
	assign rl = (run_v_q && !complete && !demote) ? run_l_q : plvl2;

	logic [TimeW-1:0] time_inc;
	assign time_inc = (time_q != TimeMax) ? time_q + 1'b1 : time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			started_q <= '0;
			run_v_q   <= 1'b0;
			run_t_q   <= '0;
			run_l_q   <= '0;
			slice_q   <= '0;
			swl_q     <= '0;
			time_q    <= '0;
			for (int l = 0; l < 3; l++) begin
				head_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
		end else if (ctrl.exec) begin
			if (arrive_ok) begin
				active_q[aid]  <= 1'b1;
				started_q[aid] <= 1'b0;
				if (cnt_q[0] < Full) cnt_q[0] <= cnt_q[0] + 1'b1;
			end else if (status.is_tick) begin
				time_q <= time_inc;
				if (complete) begin
					active_q[run_t_q] <= 1'b0;
					run_v_q <= 1'b0;
					slice_q <= '0;
				end
				if (demote) begin
					run_v_q <= 1'b0;
					slice_q <= '0;
				end
				if (sw_busy) begin
					swl_q <= (complete || demote) ? sw_q - 1'b1 : swl_q - 1'b1;
					if (demote && push_d_ok)
						cnt_q[run_l_q + 2'd1] <= cnt_q[run_l_q + 2'd1] + 1'b1;
				end else begin
					if (complete || demote) swl_q <= '0;
					if (pick) begin
						run_v_q <= 1'b1;
						run_t_q <= rt;
						run_l_q <= rl;
						slice_q <= 8'd1;
						head_q[plvl2] <= (head_q[plvl2] == LastSlot) ? '0 :
							head_q[plvl2] + 1'b1;
						if (!(demote && push_d_ok && plvl2 == run_l_q + 2'd1))
							cnt_q[plvl2] <= cnt_q[plvl2] - 1'b1;
						if (demote && push_d_ok && plvl2 != run_l_q + 2'd1)
							cnt_q[run_l_q + 2'd1] <= cnt_q[run_l_q + 2'd1] + 1'b1;
						if (!started_q[rt]) started_q[rt] <= 1'b1;
					end else if (run_now) begin
						if (slice_q != 8'hFF) slice_q <= slice_q + 1'b1;
					end else if (demote && push_d_ok) begin
						cnt_q[run_l_q + 2'd1] <= cnt_q[run_l_q + 2'd1] + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (arrive_ok) begin
			arr_m[aid]   <= time_q;
			burst_m[aid] <= burst_q;
			rem_m[aid]   <= burst_q;
			start_m[aid] <= '0;
			if (cnt_q[0] < Full) fifo_m[0][push_pos0] <= id_q;
		end else if (ctrl.exec && status.is_tick) begin
			if (demote && push_d_ok)
				fifo_m[run_l_q + 2'd1][push_pos_d] <= IdW'(run_t_q);
			if (pick && !started_q[rt]) start_m[rt] <= time_q;
			if (run_now && rem_m[rt] != '0) rem_m[rt] <= rem_m[rt] - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			running_valid   <= run_now;
			running_task    <= run_now ? IdW'(rt) : '0;
			running_level   <= run_now ? rl : '0;
			done_valid      <= complete;
			done_task       <= complete ? IdW'(run_t_q) : '0;
			finish_time     <= complete ? time_q : '0;
			turnaround_time <= complete ? turn : '0;
			waiting_time    <= (complete && turn >= TimeW'(r_burst_s1)) ?
				turn - TimeW'(r_burst_s1) : '0;
			response_time   <= complete ? resp : '0;
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= Full) && (cnt_q[1] <= Full) && (cnt_q[2] <= Full))
		else $error("queue count overflow");
	a_run_active: assert property (@(posedge clk) disable iff (!arst_n)
		run_v_q |-> active_q[run_t_q])
		else $error("running task not active");
	a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.exec && status.is_tick && time_q != TimeMax) |=> time_q == $past(time_q) + 1'b1)
		else $error("time did not advance");

endmodule

// ===== rtl/core/multilevel_feedback_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// multilevel_feedback_task_scheduler
// Three-level feedback queue scheduler advanced one time unit per tick.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready: command 0 records an arriving task,
// command 1 advances one time tick. Each tick request yields one result on
// out_valid/out_ready carrying the task that ran and any completion with its
// finish, turnaround, waiting and response times; arrive requests yield none.
// A request passes through capture, table read and execute, plus result
// presentation for a tick, all stepped by the sequencer; one request is in
// flight at a time. While the receiver stalls, the result holds and no new
// request is taken. Reset clears the queues, task flags, run state and time,
// and restores the register defaults (quanta 8 and 16, no switch cost).
// Registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module multilevel_feedback_task_scheduler import mlfq_pkg::*; #(
	parameter int MAX_TASKS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              command,
	input  logic [IdW-1:0]    task_id,
	input  logic [BurstW-1:0] burst_length,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              running_valid,
	output logic [IdW-1:0]    running_task,
	output logic [LevelW-1:0] running_level,
	output logic              done_valid,
	output logic [IdW-1:0]    done_task,
	output logic [TimeW-1:0]  finish_time,
	output logic [TimeW-1:0]  turnaround_time,
	output logic [TimeW-1:0]  waiting_time,
	output logic [TimeW-1:0]  response_time
);

	ctrl_t   ctrl;
	status_t status;

	mlfq_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.status, .ctrl
	);

	mlfq_dp #(.MaxTasks(MAX_TASKS)) u_dp (
		.clk, .arst_n, .ctrl, .status,
		.cfg_we, .cfg_idx(cfg_index), .cfg_data,
		.command, .task_id, .burst_length,
		.running_valid, .running_task, .running_level,
		.done_valid, .done_task, .finish_time, .turnaround_time,
		.waiting_time, .response_time
	);

endmodule

// ===== test/multilevel_feedback_task_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// multilevel_feedback_task_scheduler_tb
// Self-checking bench for the three-level feedback queue scheduler.
// Requests are sent on the valid/ready input. A scheduler model inside the
// bench predicts each tick report, and every report is compared field by
// field. Directed tests cover reset defaults, dropped arrivals, quantum and
// switch-cost extremes and back-pressure; a random run under several register
// settings follows, and a maximum-length burst closes the sequence.
// ----------------------------------------------------------------------------
module multilevel_feedback_task_scheduler_tb import mlfq_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] RegUnused = 2'd3;
	localparam int CycleLimit = 200000;

	typedef struct packed {
		logic              ran;
		logic [IdW-1:0]    ran_task;
		logic [LevelW-1:0] ran_level;
		logic              done;
		logic [IdW-1:0]    done_id;
		logic [TimeW-1:0]  finish;
		logic [TimeW-1:0]  turnaround;
		logic [TimeW-1:0]  waited;
		logic [TimeW-1:0]  response;
	} tick_report_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [7:0]        cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              command = CmdTick;
	logic [IdW-1:0]    task_id = '0;
	logic [BurstW-1:0] burst_length = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              running_valid;
	logic [IdW-1:0]    running_task;
	logic [LevelW-1:0] running_level;
	logic              done_valid;
	logic [IdW-1:0]    done_task;
	logic [TimeW-1:0]  finish_time;
	logic [TimeW-1:0]  turnaround_time;
	logic [TimeW-1:0]  waiting_time;
	logic [TimeW-1:0]  response_time;

	multilevel_feedback_task_scheduler dut (.*);

	always #5 clk = ~clk;

	// Scheduler model state.
	logic [7:0]        quantum0, quantum1;
	logic [3:0]        switch_cost;
	logic [TimeW-1:0]  now;
	logic [TimeW-1:0]  arrived_at[16];
	logic [BurstW-1:0] burst_of[16];
	logic [BurstW-1:0] left_of[16];
	logic [TimeW-1:0]  started_at[16];
	logic              started[16];
	logic              active[16];
	logic [IdW-1:0]    level_queue[3][$];
	logic              cur_valid;
	logic [IdW-1:0]    cur_task;
	logic [1:0]        cur_level;
	logic [7:0]        slice;
	logic [3:0]        switch_pending;

	tick_report_t expected_reports[$];
	int errors = 0;
	int reports_seen = 0;
	int completions = 0;
	int drops = 0;
	int cycles = 0;
	bit quiet = 0;
	int hold_left = 0;

	function automatic void reset_model();
		quantum0 = 8;
		quantum1 = 16;
		switch_cost = 0;
		now = '0;
		cur_valid = 0;
		cur_task = '0;
		cur_level = '0;
		slice = '0;
		switch_pending = '0;
		for (int i = 0; i < 16; i++) begin
			started[i] = 0;
			active[i] = 0;
		end
		for (int l = 0; l < 3; l++) level_queue[l].delete();
	endfunction

	function automatic void advance_time();
		if (now != TimeMax) now = now + 1'b1;
	endfunction

	function automatic void record_arrival(logic [IdW-1:0] id, logic [BurstW-1:0] burst);
		if (active[id] || burst == 0) begin
			drops++;
			return;
		end
		arrived_at[id] = now;
		burst_of[id] = burst;
		left_of[id] = burst;
		started_at[id] = '0;
		started[id] = 0;
		active[id] = 1;
		level_queue[0] = {level_queue[0], id};
	endfunction

	function automatic void schedule_tick();
		tick_report_t r;
		logic [TimeW-1:0] turn;
		r = '0;
		if (cur_valid) begin
			if (left_of[cur_task] == 0) begin
				turn = now - arrived_at[cur_task];
				r.done = 1;
				r.done_id = cur_task;
				r.finish = now;
				r.turnaround = turn;
				r.waited = (turn >= TimeW'(burst_of[cur_task])) ?
					turn - TimeW'(burst_of[cur_task]) : '0;
				r.response = started_at[cur_task] - arrived_at[cur_task];
				active[cur_task] = 0;
				cur_valid = 0;
				slice = 0;
				if (level_queue[0].size() || level_queue[1].size() || level_queue[2].size())
					switch_pending = switch_cost;
			end else if ((cur_level == 0 && slice >= quantum0) ||
					(cur_level == 1 && slice >= quantum1)) begin
				level_queue[cur_level + 1] = {level_queue[cur_level + 1], cur_task};
				cur_valid = 0;
				slice = 0;
				switch_pending = switch_cost;
			end
		end
		if (switch_pending != 0) begin
			switch_pending--;
			advance_time();
			expected_reports = {expected_reports, r};
			return;
		end
		if (!cur_valid) begin
			for (int l = 0; l < 3; l++) begin
				if (level_queue[l].size() != 0) begin
					cur_task = level_queue[l][0];
					level_queue[l].delete(0);
					cur_level = 2'(l);
					cur_valid = 1;
					slice = 0;
					if (!started[cur_task]) begin
						started[cur_task] = 1;
						started_at[cur_task] = now;
					end
					break;
				end
			end
		end
		if (cur_valid) begin
			if (left_of[cur_task] != 0) left_of[cur_task]--;
			if (slice != 8'hFF) slice++;
			r.ran = 1;
			r.ran_task = cur_task;
			r.ran_level = cur_level;
		end
		advance_time();
		expected_reports = {expected_reports, r};
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("%0t: timeout with %0d reports outstanding", $time,
				expected_reports.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, a long hold-off on request, none while quiet.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 8);
		end
	end

	function automatic void check_field(string name, logic [TimeW-1:0] want,
			logic [TimeW-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		tick_report_t e;
		if (arst_n && out_valid && out_ready) begin
			reports_seen++;
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected report, actual task %0d", $time, running_task);
				errors++;
			end else begin
				e = expected_reports[0];
				expected_reports.delete(0);
				if (e.done) completions++;
				check_field("running_valid", TimeW'(e.ran), TimeW'(running_valid));
				check_field("running_task", TimeW'(e.ran_task), TimeW'(running_task));
				check_field("running_level", TimeW'(e.ran_level), TimeW'(running_level));
				check_field("done_valid", TimeW'(e.done), TimeW'(done_valid));
				check_field("done_task", TimeW'(e.done_id), TimeW'(done_task));
				check_field("finish_time", e.finish, finish_time);
				check_field("turnaround_time", e.turnaround, turnaround_time);
				check_field("waiting_time", e.waited, waiting_time);
				check_field("response_time", e.response, response_time);
			end
		end
	end

	task automatic send(logic cmd, logic [IdW-1:0] id, logic [BurstW-1:0] burst);
		if (!quiet && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		task_id <= id;
		burst_length <= burst;
		do @(posedge clk); while (!in_ready);
		if (cmd == CmdArrive) record_arrival(id, burst);
		else schedule_tick();
	endtask

	task automatic ticks(int n);
		repeat (n) send(CmdTick, IdW'($urandom_range(15)), BurstW'($urandom));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == RegQuantum0) quantum0 = value;
		else if (idx == RegQuantum1) quantum1 = value;
		else if (idx == RegSwitch) switch_cost = value[3:0];
		@(posedge clk);
	endtask

	task automatic set_regs(logic [7:0] q0, logic [7:0] q1, logic [3:0] sw);
		drain();
		write_reg(RegQuantum0, q0);
		write_reg(RegQuantum1, q1);
		write_reg(RegSwitch, {4'h0, sw});
	endtask

	task automatic test_defaults();
		ticks(2);
		send(CmdArrive, 4'd0, 16'd1);
		send(CmdArrive, 4'd15, 16'd20);
		send(CmdArrive, 4'd15, 16'd3);
		send(CmdArrive, 4'd5, 16'd0);
		ticks(30);
	endtask

	task automatic test_register_extremes();
		set_regs(8'd0, 8'd255, 4'd15);
		write_reg(RegUnused, 8'hAA);
		send(CmdArrive, 4'd10, 16'd6);
		send(CmdArrive, 4'd6, 16'd2);
		ticks(70);
		set_regs(8'd1, 8'd1, 4'd0);
		for (int i = 0; i < 16; i++) send(CmdArrive, IdW'(i), 16'd4);
		ticks(70);
		set_regs(8'd255, 8'd0, 4'd1);
		send(CmdArrive, 4'd3, 16'd270);
		send(CmdArrive, 4'd9, 16'd2);
		ticks(280);
	endtask

	task automatic test_backpressure();
		set_regs(8'd3, 8'd5, 4'd2);
		hold_left = 300;
		for (int i = 0; i < 4; i++) send(CmdArrive, IdW'(1 + i), 16'd5);
		ticks(30);
		drain();
		ticks(10);
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 3; phase++) begin
			set_regs(8'($urandom_range(1, 12)), 8'($urandom_range(1, 24)),
				4'($urandom_range(0, 3)));
			quiet = (phase == 1);
			repeat (55) begin
				if ($urandom_range(99) < 25)
					send(CmdArrive, IdW'($urandom_range(15)),
						BurstW'(($urandom_range(99) < 3) ? $urandom_range(1, 200) :
						$urandom_range(0, 30)));
				else
					ticks(1);
			end
			quiet = 0;
		end
	endtask

	task automatic test_long_burst();
		logic [IdW-1:0] slot;
		slot = 4'd7;
		set_regs(8'd255, 8'd255, 4'd0);
		for (int i = 0; i < 16; i++) if (!active[i]) slot = IdW'(i);
		send(CmdArrive, slot, 16'hFFFF);
		quiet = 1;
		ticks(30);
		quiet = 0;
	endtask

	initial begin
		reset_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_register_extremes();
		test_backpressure();
		test_random();
		test_long_burst();
		drain();
		repeat (20) @(posedge clk);
		if (expected_reports.size() != 0) begin
			$display("%0t: %0d expected reports never arrived", $time, expected_reports.size());
			errors++;
		end
		$display("Checked %0d tick reports with %0d completions; %0d arrivals dropped.",
			reports_seen, completions, drops);
		$display("Covered quanta 0 to 255, switch cost 0 to 15, back-pressure, maximum burst.");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
